// ----- sv/deq_pkg.sv -----
// Package for the double-ended queue: opcode and status codes and default sizes.
// Depends on nothing; used by double_ended_queue.
`default_nettype none

package deq_pkg;

    // Default sizes of the circular store.
    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_DATA_WIDTH = 32;

    // Operation codes carried with each request.
    typedef enum logic [2:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_POP_HEAD  = 3'd1,
        OP_PEEK_HEAD = 3'd2,
        OP_PUSH_REAR = 3'd3,
        OP_POP_REAR  = 3'd4,
        OP_PEEK_REAR = 3'd5
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- sv/double_ended_queue.sv -----
// Bounded double-ended queue held in a circular synchronous memory.
// Depends on deq_pkg for the opcode and status codes and the default sizes.
//
// Use: the s_ channel carries one request per item (s_opcode, s_value) under a
// valid/ready handshake. Each request yields exactly one result on the m_
// channel (m_data, m_status, m_fill_count), in request order. Pushes write the
// head or rear end, pops remove and return an element, peeks return it and
// leave the store alone. A push to a full store is dropped with status full;
// a pop or peek on an empty store returns status empty and changes nothing.
// Unused opcodes return status ok, zero data and the unchanged fill count.
//
// Timing: a push, a refused request or an unused opcode shows its result in
// the cycle after acceptance and the next request may follow at once. A pop
// or peek reads the memory, whose single read port is registered, so its
// result passes through the read data register into the output register,
// and no new request is taken while that read is pending.
// The result sits in an output register; while m_ready is low it holds and
// s_ready stays low, so no request is lost. Reset empties the store at once:
// both end pointers and the fill count return to zero, no clearing pass.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [2:0]            s_opcode,
    input  wire logic [DATA_WIDTH-1:0] s_value,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_WIDTH-1:0]      m_data,
    output deq_pkg::status_t           m_status,
    output logic [CNT_W-1:0]           m_fill_count
);
    import deq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Element memory: one write and one registered read per cycle.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // End pointers and fill count.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Pending read result, waiting for the memory data.
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_fill_reg, pend_fill_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] m_data_reg, m_data_next;
    status_t               m_status_reg, m_status_next;
    logic [CNT_W-1:0]      m_fill_reg, m_fill_next;

    // Request decode and memory access controls.
    logic             s_fire;
    logic             is_empty, is_full;
    logic             is_push;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [IDX_W-1:0] head_prev, head_succ, rear_prev, rear_succ;
    status_t          req_status;

    // A request is taken only when no read is in flight and the output frees up.
    assign s_ready  = !pend_reg && (!m_valid_reg || m_ready);
    assign s_fire   = s_valid && s_ready;
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == FULL_CNT);

    // Circular neighbors of both pointers.
    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign rear_prev = (rear_reg == '0) ? LAST_IDX : rear_reg - IDX_W'(1);
    assign rear_succ = (rear_reg == LAST_IDX) ? '0 : rear_reg + IDX_W'(1);

    // Pointer, count and memory control for the offered request.
    always_comb begin
        head_next  = head_reg;
        rear_next  = rear_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        rd_en      = 1'b0;
        rd_addr    = rear_reg;
        req_status = ST_OK;
        is_push    = 1'b0;
        unique case (s_opcode)
            OP_PUSH_HEAD: begin
                is_push = 1'b1;
                if (is_full) begin
                    req_status = ST_FULL;
                end else begin
                    wr_en     = s_fire;
                    wr_addr   = head_reg;
                    head_next = head_succ;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            OP_POP_HEAD, OP_PEEK_HEAD: begin
                if (is_empty) begin
                    req_status = ST_EMPTY;
                end else begin
                    rd_en   = s_fire;
                    rd_addr = head_prev;
                    if (s_opcode == OP_POP_HEAD) begin
                        head_next = head_prev;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
            end
            OP_PUSH_REAR: begin
                is_push = 1'b1;
                if (is_full) begin
                    req_status = ST_FULL;
                end else begin
                    wr_en     = s_fire;
                    wr_addr   = rear_prev;
                    rear_next = rear_prev;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            OP_POP_REAR, OP_PEEK_REAR: begin
                if (is_empty) begin
                    req_status = ST_EMPTY;
                end else begin
                    rd_en   = s_fire;
                    rd_addr = rear_reg;
                    if (s_opcode == OP_POP_REAR) begin
                        rear_next = rear_succ;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                // Unused opcodes change nothing.
            end
        endcase
    end

    // Result path: pending reads land first, other requests go straight out.
    always_comb begin
        pend_next      = 1'b0;
        pend_fill_next = pend_fill_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        m_status_next  = m_status_reg;
        m_fill_next    = m_fill_reg;
        if (pend_reg) begin
            m_valid_next  = 1'b1;
            m_data_next   = rd_data_reg;
            m_status_next = ST_OK;
            m_fill_next   = pend_fill_reg;
        end else if (s_fire && rd_en) begin
            pend_next      = 1'b1;
            pend_fill_next = cnt_next;
        end else if (s_fire) begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_status_next = req_status;
            m_fill_next   = cnt_next;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            rear_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                head_reg <= head_next;
                rear_reg <= rear_next;
                cnt_reg  <= cnt_next;
            end
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        pend_fill_reg <= pend_fill_next;
        m_data_reg    <= m_data_next;
        m_status_reg  <= m_status_next;
        m_fill_reg    <= m_fill_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign m_status     = m_status_reg;
    assign m_fill_count = m_fill_reg;

    // A read in flight always lands in the output register in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> (m_valid_reg && m_status_reg == ST_OK))
        else $error("pending read result did not reach the output");

    // The fill count never exceeds the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("fill count above depth");

    // An empty store has both end pointers at the same slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (head_reg == rear_reg))
        else $error("empty store with pointers apart");

    // An accepted push into a store with room grows the count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_push && !is_full) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("push did not grow the fill count");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the double-ended queue: drives opcode requests, predicts
// every result from a shadow copy of the circular store and compares them in order.
// Depends on deq_pkg and double_ended_queue.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int CNT_W        = $clog2(DEQ_DEPTH + 1);
    localparam int IDLE_PCT     = 28;
    localparam int RANDOM_ITEMS = 750;
    localparam int MAX_REPORTS  = 10;

    // Opcodes outside the defined set; the block must ignore them.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]                opcode;
        logic [DEQ_DATA_WIDTH-1:0] value;
        logic                      drain;
    } request_t;

    typedef struct packed {
        logic [DEQ_DATA_WIDTH-1:0] data;
        status_t                   status;
        logic [CNT_W-1:0]          fill;
    } result_t;

    logic                      aclk;
    logic                      aresetn  = 1'b0;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    logic [2:0]                s_opcode = OP_PUSH_HEAD;
    logic [DEQ_DATA_WIDTH-1:0] s_value  = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic [DEQ_DATA_WIDTH-1:0] m_data;
    status_t                   m_status;
    logic [CNT_W-1:0]          m_fill_count;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       mismatches    = 0;
    int       in_flight     = 0;
    int       requests_done = 0;
    logic     steady        = 1'b0;

    // Shadow of the deque contents and its end indices.
    logic [DEQ_DATA_WIDTH-1:0] shadow_store [DEQ_DEPTH];
    int shadow_head = 0;
    int shadow_rear = 0;
    int shadow_fill = 0;

    double_ended_queue i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .m_status     (m_status),
        .m_fill_count (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Applies one request to the shadow deque and returns the result it should give.
    function automatic result_t apply_request(logic [2:0] opcode,
                                              logic [DEQ_DATA_WIDTH-1:0] value);
        result_t res;
        int      slot;
        res.data   = '0;
        res.status = ST_OK;
        case (opcode)
            OP_PUSH_HEAD, OP_PUSH_REAR: begin
                if (shadow_fill >= DEQ_DEPTH) begin
                    res.status = ST_FULL;
                end else if (opcode == OP_PUSH_HEAD) begin
                    shadow_store[shadow_head] = value;
                    shadow_head = (shadow_head + 1) % DEQ_DEPTH;
                    shadow_fill++;
                end else begin
                    shadow_rear = (shadow_rear + DEQ_DEPTH - 1) % DEQ_DEPTH;
                    shadow_store[shadow_rear] = value;
                    shadow_fill++;
                end
            end
            OP_POP_HEAD, OP_PEEK_HEAD: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = (shadow_head + DEQ_DEPTH - 1) % DEQ_DEPTH;
                    res.data = shadow_store[slot];
                    if (opcode == OP_POP_HEAD) begin
                        shadow_head = slot;
                        shadow_fill--;
                    end
                end
            end
            OP_POP_REAR, OP_PEEK_REAR: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = shadow_store[shadow_rear];
                    if (opcode == OP_POP_REAR) begin
                        shadow_rear = (shadow_rear + 1) % DEQ_DEPTH;
                        shadow_fill--;
                    end
                end
            end
            default: ;
        endcase
        res.fill = CNT_W'(shadow_fill);
        return res;
    endfunction

    task automatic add_request(logic [2:0] opcode, logic [DEQ_DATA_WIDTH-1:0] value,
                               logic drain);
        request_t req;
        req.opcode = opcode;
        req.value  = value;
        req.drain  = drain;
        pending_requests.push_back(req);
    endtask

    // Mostly random words, with the all-zero and all-one patterns mixed in.
    function automatic logic [DEQ_DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Request driver: predicts each accepted request and presents the next pending one.
    always @(posedge aclk) begin
        request_t next_req;
        logic     accepted;
        logic     offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            accepted = s_valid && s_ready;
            if (accepted) begin
                expected_results.push_back(apply_request(s_opcode, s_value));
                requests_done++;
            end
            in_flight = in_flight + int'(accepted) - int'(m_valid && m_ready);
            offer = s_valid && !accepted;
            // A request marked for draining waits until every result is back.
            if (!offer && pending_requests.size() > 0
                    && !(pending_requests[0].drain && in_flight != 0)
                    && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_req = pending_requests.pop_front();
                s_opcode <= next_req.opcode;
                s_value  <= next_req.value;
                offer = 1'b1;
            end
            s_valid <= offer;
            steady  <= requests_done >= 300 && requests_done < 480;
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("unexpected result: data %h status %0d fill %0d",
                                         m_data, m_status, m_fill_count));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data !== want.data || m_status !== want.status
                            || m_fill_count !== want.fill) begin
                        flag_error($sformatf(
                            "mismatch: expected data %h status %0d fill %0d, got %h %0d %0d",
                            want.data, want.status, want.fill,
                            m_data, m_status, m_fill_count));
                    end
                end
            end
            m_ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [2:0] op;
        int         counted;
        int         shape;
        int         burst;
        logic       drain;

        // Every pop and peek on an empty store, then the spare opcodes.
        add_request(OP_POP_HEAD, '1, 1'b0);
        add_request(OP_PEEK_HEAD, '0, 1'b0);
        add_request(OP_POP_REAR, '1, 1'b0);
        add_request(OP_PEEK_REAR, '0, 1'b0);
        add_request(OP_SPARE_6, '1, 1'b0);
        add_request(OP_SPARE_7, 32'h5555_5555, 1'b0);
        // Fill from both ends, then push into the full store at each end.
        for (int k = 0; k < DEQ_DEPTH; k++) begin
            add_request((k % 2 == 0) ? OP_PUSH_HEAD : OP_PUSH_REAR,
                        (k == 0) ? '1 : (k == 1) ? '0 : $urandom(), 1'b0);
        end
        add_request(OP_PUSH_HEAD, 32'hAAAA_AAAA, 1'b0);
        add_request(OP_PUSH_REAR, 32'h5555_5555, 1'b0);
        add_request(OP_PEEK_HEAD, '0, 1'b0);
        add_request(OP_PEEK_REAR, '0, 1'b0);

        // Random bursts: fills, drains, mixed traffic and spare-opcode noise.
        counted = 0;
        drain   = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            shape = $urandom_range(99);
            burst = $urandom_range(4, 20);
            for (int j = 0; j < burst; j++) begin
                if (shape < 25) begin
                    op = $urandom_range(1) ? OP_PUSH_HEAD : OP_PUSH_REAR;
                end else if (shape < 50) begin
                    if ($urandom_range(3) == 0) begin
                        op = $urandom_range(1) ? OP_PEEK_HEAD : OP_PEEK_REAR;
                    end else begin
                        op = $urandom_range(1) ? OP_POP_HEAD : OP_POP_REAR;
                    end
                end else if (shape < 92) begin
                    op = 3'($urandom_range(5));
                end else begin
                    op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
                end
                add_request(op, pick_value(), drain && j == 0);
                if (op != OP_SPARE_6 && op != OP_SPARE_7) begin
                    counted++;
                end
            end
            drain = ($urandom_range(9) == 0);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
